@@ src/ptr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptr_pkg: shared types and constants for the pan/tilt position ramp
// Field widths, item kinds, register indexes and the structs that pass
// between the scaler, the axis units and the top level.
// ----------------------------------------------------------------------------
package ptr_pkg;

	// whole-count width of positions, centers and limits
	localparam int POS_BITS   = 12;
	localparam int KIND_W     = 3;
	localparam int ANGLE_W    = 8;
	localparam int SPEED_W    = 8;
	localparam int DEG_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	// scaled product / quotient magnitude: 8-bit operand times count range
	localparam int QUO_W      = ANGLE_W + POS_BITS;
	localparam int CNT_W      = $clog2(QUO_W);

	localparam int S_TDATA_W  = 32;
	localparam int S_TUSER_W  = 4;
	localparam int M_TDATA_W  = 32;

	// register reset values
	localparam logic [POS_BITS-1:0] RST_FS_COUNTS = 12'd1023;
	localparam logic [DEG_W-1:0]    RST_FS_DEG    = 9'd300;
	localparam logic [POS_BITS-1:0] RST_CENTER    = 12'd512;
	localparam logic [POS_BITS-1:0] RST_CW        = 12'd0;
	localparam logic [POS_BITS-1:0] RST_CCW       = 12'd1023;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 3'd0,
		KIND_MOVE  = 3'd1,
		KIND_SPEED = 3'd2,
		KIND_STOP  = 3'd3,
		KIND_LOAD  = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FS_COUNTS = 3'd0,
		CFG_FS_DEG    = 3'd1,
		CFG_PAN_CTR   = 3'd2,
		CFG_PAN_CW    = 3'd3,
		CFG_PAN_CCW   = 3'd4,
		CFG_TILT_CTR  = 3'd5,
		CFG_TILT_CW   = 3'd6,
		CFG_TILT_CCW  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic               start;
		logic               signed_op;
		logic [ANGLE_W-1:0] operand;
	} scale_req_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [QUO_W-1:0] quo;
	} scale_rsp_t;

	typedef struct packed {
		logic                en;
		logic [KIND_W-1:0]   kind;
		logic [POS_BITS-1:0] load_count;
	} axis_cmd_t;

	typedef struct packed {
		logic [POS_BITS-1:0] center;
		logic [POS_BITS-1:0] cw;
		logic [POS_BITS-1:0] ccw;
	} axis_cfg_t;

	typedef struct packed {
		logic                moving;
		logic [POS_BITS-1:0] position;
	} axis_stat_t;

endpackage

@@ src/pan_tilt_position_ramp_core.sv @@
// ----------------------------------------------------------------------------
// pan_tilt_position_ramp_core: two-axis servo position slew-rate limiter
// Command decode, configuration registers, sequencing and result register.
// ----------------------------------------------------------------------------
// One item is worked at a time. Tick, stop, load and unused kinds go from
// accept through the apply and output states; move and set-speed items also
// pass the bit-serial scaler (8 shift-add multiply steps and 20 restoring
// divide steps) first. A new item is taken as soon as the previous one has
// written its result into the output register, even if that beat is still
// waiting for m_tready. Each item returns exactly one beat with both
// whole-count positions and both moving flags. Configuration writes are always
// ready and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
module pan_tilt_position_ramp_core
	import ptr_pkg::*;
#(
	parameter int FRAC_BITS = 7     // fraction bits of the position ramp
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // angle_deg[7:0], speed_deg[15:8],
	                                         // position_count[27:16], zero pad
	input  logic [S_TUSER_W-1:0]  s_tuser,   // kind[2:0], axis[3]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // pan_position[11:0], tilt_position[23:12],
	                                         // pan_busy[24], tilt_busy[25], zero pad
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCALE = 4'b0010,
		ST_APPLY = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t              state_q;

	// configuration registers
	logic [POS_BITS-1:0] fs_counts_q;
	logic [DEG_W-1:0]    fs_deg_q;
	axis_cfg_t           pan_cfg_q, tilt_cfg_q;

	// captured item
	logic [KIND_W-1:0]   kind_q;
	logic                axis_q;
	logic [POS_BITS-1:0] load_q;

	// result register
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                in_beat;
	logic                needs_scale;
	logic                out_free;
	scale_req_t          sc_req;
	scale_rsp_t          sc_rsp;
	axis_cmd_t           pan_cmd, tilt_cmd;
	axis_stat_t          pan_stat, tilt_stat;
	logic                is_tick;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	// moves and speed changes go through the scaler
	assign needs_scale = (s_tuser[KIND_W-1:0] == KIND_MOVE) ||
	                     (s_tuser[KIND_W-1:0] == KIND_SPEED);

	// move scales the signed angle, set-speed the unsigned speed
	assign sc_req.start     = in_beat && needs_scale;
	assign sc_req.signed_op = (s_tuser[KIND_W-1:0] == KIND_MOVE);
	assign sc_req.operand   = sc_req.signed_op ? s_tdata[ANGLE_W-1:0]
	                                           : s_tdata[ANGLE_W +: SPEED_W];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat)
						state_q <= needs_scale ? ST_SCALE : ST_APPLY;
				end
				ST_SCALE: begin
					if (sc_rsp.done)
						state_q <= ST_APPLY;
				end
				ST_APPLY: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_q <= s_tuser[KIND_W-1:0];
			axis_q <= s_tuser[KIND_W];
			load_q <= s_tdata[ANGLE_W + SPEED_W +: POS_BITS];
		end
	end

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_counts_q       <= RST_FS_COUNTS;
			fs_deg_q          <= RST_FS_DEG;
			pan_cfg_q.center  <= RST_CENTER;
			pan_cfg_q.cw      <= RST_CW;
			pan_cfg_q.ccw     <= RST_CCW;
			tilt_cfg_q.center <= RST_CENTER;
			tilt_cfg_q.cw     <= RST_CW;
			tilt_cfg_q.ccw    <= RST_CCW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FS_COUNTS: fs_counts_q       <= cfg_data[POS_BITS-1:0];
				CFG_FS_DEG:    fs_deg_q          <= cfg_data[DEG_W-1:0];
				CFG_PAN_CTR:   pan_cfg_q.center  <= cfg_data[POS_BITS-1:0];
				CFG_PAN_CW:    pan_cfg_q.cw      <= cfg_data[POS_BITS-1:0];
				CFG_PAN_CCW:   pan_cfg_q.ccw     <= cfg_data[POS_BITS-1:0];
				CFG_TILT_CTR:  tilt_cfg_q.center <= cfg_data[POS_BITS-1:0];
				CFG_TILT_CW:   tilt_cfg_q.cw     <= cfg_data[POS_BITS-1:0];
				CFG_TILT_CCW:  tilt_cfg_q.ccw    <= cfg_data[POS_BITS-1:0];
				default: ;
			endcase
		end
	end

	ptr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (sc_req),
		.fs_counts (fs_counts_q),
		.fs_deg    (fs_deg_q),
		.rsp       (sc_rsp)
	);

	// a tick steps both axes; other kinds go to the selected one
	assign is_tick = (kind_q == KIND_TICK);

	assign pan_cmd.en          = (state_q == ST_APPLY) && (is_tick || !axis_q);
	assign pan_cmd.kind        = kind_q;
	assign pan_cmd.load_count  = load_q;
	assign tilt_cmd.en         = (state_q == ST_APPLY) && (is_tick || axis_q);
	assign tilt_cmd.kind       = kind_q;
	assign tilt_cmd.load_count = load_q;

	ptr_axis #(.FRAC_BITS(FRAC_BITS)) u_pan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (pan_cmd),
		.cfg     (pan_cfg_q),
		.quo_neg (sc_rsp.neg),
		.quo     (sc_rsp.quo),
		.stat    (pan_stat)
	);

	ptr_axis #(.FRAC_BITS(FRAC_BITS)) u_tilt (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (tilt_cmd),
		.cfg     (tilt_cfg_q),
		.quo_neg (sc_rsp.neg),
		.quo     (sc_rsp.quo),
		.stat    (tilt_stat)
	);

	// result register: loaded once the axes hold the post-item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free)
			m_tdata_q <= M_TDATA_W'({tilt_stat.moving, pan_stat.moving,
			                         tilt_stat.position, pan_stat.position});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ src/ptr_scale.sv @@
// ----------------------------------------------------------------------------
// ptr_scale: bit-serial degree-to-count scaler
// Shift-add multiply of an 8-bit operand by the full-scale counts, then a
// restoring divide by the full-scale degrees, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptr_scale
	import ptr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  scale_req_t          req,
	input  logic [POS_BITS-1:0] fs_counts,
	input  logic [DEG_W-1:0]    fs_deg,
	output scale_rsp_t          rsp
);

	typedef enum logic [2:0] {
		SC_IDLE = 3'b001,
		SC_MUL  = 3'b010,
		SC_DIV  = 3'b100
	} sc_state_t;

	sc_state_t          state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ANGLE_W-1:0] mplier_q;
	logic [QUO_W-1:0]   mcand_q;
	logic [QUO_W-1:0]   acc_q;      // product, then numerator/quotient shift reg
	logic [DEG_W-1:0]   rem_q;
	logic [DEG_W-1:0]   dvs_q;
	logic               neg_q;
	logic               done_q;

	logic [DEG_W:0]     rem_sh;
	logic               q_bit;
	logic [ANGLE_W-1:0] op_mag;

	assign op_mag = (req.signed_op && req.operand[ANGLE_W-1]) ? (~req.operand + 1'b1)
	                                                          : req.operand;
	assign rem_sh = {rem_q, acc_q[QUO_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						state_q <= SC_MUL;
						cnt_q   <= '0;
					end
				end
				SC_MUL: begin
					if (cnt_q == CNT_W'(ANGLE_W - 1)) begin
						state_q <= SC_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				SC_DIV: begin
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= SC_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (req.start) begin
					mplier_q <= op_mag;
					mcand_q  <= QUO_W'(fs_counts);
					acc_q    <= '0;
					neg_q    <= req.signed_op & req.operand[ANGLE_W-1];
					dvs_q    <= (fs_deg == '0) ? DEG_W'(1) : fs_deg;
				end
			end
			SC_MUL: begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[QUO_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[ANGLE_W-1:1]};
				rem_q    <= '0;
			end
			SC_DIV: begin
				rem_q <= q_bit ? DEG_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DEG_W-1:0];
				acc_q <= {acc_q[QUO_W-2:0], q_bit};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;
	assign rsp.quo  = acc_q;

endmodule

@@ src/ptr_axis.sv @@
// ----------------------------------------------------------------------------
// ptr_axis: state and ramp logic for one servo axis
// Holds position, target, speed, moving and stop flags; applies one command
// per enable pulse.
// ----------------------------------------------------------------------------
module ptr_axis
	import ptr_pkg::*;
#(
	parameter int FRAC_BITS = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  axis_cmd_t        cmd,
	input  axis_cfg_t        cfg,
	input  logic             quo_neg,
	input  logic [QUO_W-1:0] quo,
	output axis_stat_t       stat
);

	localparam int PW = POS_BITS + FRAC_BITS + 2;   // position
	localparam int TW = POS_BITS + FRAC_BITS;       // target
	localparam int SW = QUO_W;                      // speed
	localparam int XW = ((PW > SW) ? PW : SW) + 1;  // tick arithmetic
	localparam int AW = QUO_W + 2;                  // signed move target

	logic [PW-1:0]       pos_q, pos_d;
	logic [TW-1:0]       tgt_q, tgt_d;
	logic [SW-1:0]       spd_q, spd_d;
	logic                moving_q, moving_d;
	logic                stop_q, stop_d;

	logic [POS_BITS-1:0] whole;
	logic [PW-1:0]       snap_pos;
	logic [TW-1:0]       snap_tgt;
	logic [XW-1:0]       p_x, t_x, s_x, sum_x, diff_x;
	logic signed [AW-1:0] q_s, ang_t;
	logic [POS_BITS-1:0] t_cnt;

	assign whole    = pos_q[FRAC_BITS +: POS_BITS];
	assign snap_tgt = {whole, {FRAC_BITS{1'b0}}};
	assign snap_pos = PW'(snap_tgt);

	assign p_x    = XW'(pos_q);
	assign t_x    = XW'(tgt_q);
	assign s_x    = XW'(spd_q);
	assign sum_x  = p_x + s_x;
	assign diff_x = p_x - s_x;

	// scaled angle plus center, clamped; ccw limit checked first
	assign q_s   = quo_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
	assign ang_t = q_s + $signed(AW'(cfg.center));
	always_comb begin
		if (ang_t > $signed(AW'(cfg.ccw)))
			t_cnt = cfg.ccw;
		else if (ang_t < $signed(AW'(cfg.cw)))
			t_cnt = cfg.cw;
		else
			t_cnt = ang_t[POS_BITS-1:0];
	end

	always_comb begin
		pos_d    = pos_q;
		tgt_d    = tgt_q;
		spd_d    = spd_q;
		moving_d = moving_q;
		stop_d   = stop_q;
		if (cmd.en) begin
			case (cmd.kind)
				KIND_TICK: begin
					if (stop_q) begin
						pos_d    = snap_pos;
						tgt_d    = snap_tgt;
						spd_d    = '0;
						moving_d = 1'b0;
						stop_d   = 1'b0;
					end else if (p_x < t_x) begin
						if (sum_x >= t_x) begin
							pos_d    = PW'(tgt_q);
							moving_d = 1'b0;
						end else begin
							pos_d = sum_x[PW-1:0];
						end
					end else if (p_x > t_x) begin
						if (p_x < s_x || diff_x <= t_x) begin
							pos_d    = PW'(tgt_q);
							moving_d = 1'b0;
						end else begin
							pos_d = diff_x[PW-1:0];
						end
					end
				end
				KIND_MOVE: begin
					if (spd_q == '0) begin
						pos_d    = snap_pos;
						tgt_d    = snap_tgt;
						moving_d = 1'b0;
					end else begin
						tgt_d    = {t_cnt, {FRAC_BITS{1'b0}}};
						moving_d = (whole != t_cnt);
					end
				end
				KIND_SPEED: spd_d = quo;
				KIND_STOP:  stop_d = 1'b1;
				KIND_LOAD: begin
					tgt_d    = {cmd.load_count, {FRAC_BITS{1'b0}}};
					pos_d    = PW'({cmd.load_count, {FRAC_BITS{1'b0}}});
					spd_d    = '0;
					moving_d = 1'b0;
					stop_d   = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tgt_q    <= '0;
			spd_q    <= '0;
			moving_q <= 1'b0;
			stop_q   <= 1'b0;
		end else begin
			pos_q    <= pos_d;
			tgt_q    <= tgt_d;
			spd_q    <= spd_d;
			moving_q <= moving_d;
			stop_q   <= stop_d;
		end
	end

	assign stat.position = whole;
	assign stat.moving   = moving_q;

endmodule
